/* design/hsed_pkg.sv */
`default_nettype none
package hsed_pkg;

    // field widths
    localparam int HW    = 48;   // Hn, partial products and sums, Q.12 / Q.16
    localparam int CW    = 32;   // coefficient, Q15.16
    localparam int XW    = 16;   // x, Q3.12
    localparam int MA_W  = 32;   // multiplier operand a
    localparam int MB_W  = 25;   // multiplier operand b, one 24-bit slice plus sign
    localparam int MP_W  = MA_W + MB_W;
    localparam int SL_W  = 24;   // slice width of a 48-bit operand
    localparam int PW    = MA_W + HW;  // full width of a 32 x 48 product

    localparam int MAX_TERMS_DEF = 16;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic        REG_TERM_COUNT = 1'b0;
    localparam logic [4:0]  TERM_COUNT_RST = 5'd10;

    // action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic signed [HW-1:0] ONE_Q12 = HW'(4096);
    localparam logic signed [HW-1:0] H_MAX   = {1'b0, {(HW-1){1'b1}}};
    localparam logic signed [HW-1:0] H_MIN   = {1'b1, {(HW-1){1'b0}}};

    typedef struct packed {
        logic                  action;
        logic [3:0]            coef_index;
        logic signed [CW-1:0]  coef_value;
        logic signed [XW-1:0]  x_point;
    } t_in_item;

    typedef struct packed {
        logic signed [HW-1:0]  value;
        logic signed [HW-1:0]  first_deriv;
        logic signed [HW-1:0]  second_deriv;
        logic signed [HW-1:0]  third_deriv;
        logic                  saturated;
    } t_out_item;

    typedef struct packed {
        logic                  start;
        logic signed [XW-1:0]  x_point;
        logic [4:0]            term_count;
    } t_seq_cmd;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_seq_stat;

    typedef struct packed {
        logic                  clip;
        logic signed [HW-1:0]  val;
    } t_sat;

    // clip a wide signed value to 48 bits
    function automatic t_sat sat_h(input logic signed [PW-1:0] v);
        t_sat r;
        logic all_ones;
        logic all_zeros;
        all_ones  = &v[PW-1:HW-1];
        all_zeros = ~|v[PW-1:HW-1];
        r.clip = !(all_ones || all_zeros);
        if (r.clip) begin
            r.val = v[PW-1] ? H_MIN : H_MAX;
        end else begin
            r.val = v[HW-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/hsed_coef_ram.sv */
`default_nettype none
module hsed_coef_ram
    import hsed_pkg::*;
#(
    parameter int DEPTH = MAX_TERMS_DEF,
    parameter int AW    = $clog2(MAX_TERMS_DEF)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [CW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [CW-1:0] o_rdata
);

    logic [CW-1:0] r_mem [DEPTH];
    logic [CW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* design/hsed_mul.sv */
`default_nettype none
module hsed_mul
    import hsed_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic signed [MA_W-1:0]  i_a,
    input  wire logic signed [MB_W-1:0]  i_b,
    output logic signed      [MP_W-1:0]  o_p
);

    logic signed [MP_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

/* design/hsed_seq.sv */
`default_nettype none
module hsed_seq
    import hsed_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    parameter int AW        = $clog2(MAX_TERMS_DEF)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_seq_cmd        i_cmd,
    output t_seq_stat            o_stat,
    output t_out_item            o_res,
    input  wire logic            i_res_take,
    output logic                 o_re,
    output logic [AW-1:0]        o_raddr,
    input  wire logic [CW-1:0]   i_rdata
);

    localparam int NW = $clog2(MAX_TERMS + 1);
    localparam int KW = $clog2(8 * (MAX_TERMS - 1) * (MAX_TERMS - 2) * (MAX_TERMS - 3) + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_TERM = 8'b0000_0010,
        S_HI   = 8'b0000_0100,
        S_LO   = 8'b0000_1000,
        S_SUM  = 8'b0001_0000,
        S_POST = 8'b0010_0000,
        S_NEXT = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    typedef enum logic [1:0] {
        OP_REC1,    // x * H(n-1)
        OP_REC2,    // 2(n-1) * H(n-2)
        OP_CH,      // c[n] * H(n-d)
        OP_KP       // derivative factor * rounded product
    } t_op;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [1:0] r_d, n_d;
    logic [NW-1:0] r_n, n_n, r_terms, n_terms;
    logic signed [XW-1:0] r_x, n_x;
    logic signed [HW-1:0] r_hn, n_hn, r_w1, n_w1, r_w2, n_w2, r_w3, n_w3;
    logic [KW-1:0] r_k1, n_k1, r_k2, n_k2, r_k3, n_k3;
    logic signed [52:0] r_t1, n_t1;
    logic signed [HW-1:0] r_p, n_p;
    logic signed [MP_W-1:0] r_hi, n_hi;
    logic signed [PW-1:0] r_full, n_full;
    logic signed [HW-1:0] r_acc0, n_acc0, r_acc1, n_acc1, r_acc2, n_acc2, r_acc3, n_acc3;
    logic r_flag, n_flag;

    logic signed [HW-1:0]   h_sel;
    logic signed [MA_W-1:0] a_sel;
    logic signed [MB_W-1:0] b_sel;
    logic signed [MP_W-1:0] mul_p;
    logic [KW-1:0]          k_sel;

    logic signed [PW-1:0]   rec_sum;
    logic signed [52:0]     t1;
    logic signed [53:0]     t2;
    logic signed [54:0]     rec_diff;
    logic signed [PW-1:0]   ch_sum;
    logic signed [PW-1:0]   ch_q;
    t_sat                   h_sat, ch_sat, kp_sat, acc_sat;
    logic signed [HW-1:0]   acc_cur, add_term;
    logic signed [HW:0]     acc_sum;

    // operand select
    always_comb begin
        case (r_d)
            2'd2:    k_sel = r_k2;
            2'd3:    k_sel = r_k3;
            default: k_sel = r_k1;
        endcase
        unique case (r_op)
            OP_REC1: begin
                h_sel = r_w1;
                a_sel = MA_W'(r_x);
            end
            OP_REC2: begin
                h_sel = r_w2;
                a_sel = MA_W'(r_k1 - KW'(2));
            end
            OP_CH: begin
                case (r_d)
                    2'd0:    h_sel = r_hn;
                    2'd1:    h_sel = r_w1;
                    2'd2:    h_sel = r_w2;
                    default: h_sel = r_w3;
                endcase
                a_sel = $signed(i_rdata);
            end
            default: begin
                h_sel = r_p;
                a_sel = MA_W'(k_sel);
            end
        endcase
        // upper slice first, then the unsigned lower slice
        if (r_state == S_HI) begin
            b_sel = {h_sel[HW-1], h_sel[HW-1:SL_W]};
        end else begin
            b_sel = {1'b0, h_sel[SL_W-1:0]};
        end
    end

    hsed_mul u_mul (
        .i_clk (i_clk),
        .i_a   (a_sel),
        .i_b   (b_sel),
        .o_p   (mul_p)
    );

    // post processing of the assembled product
    always_comb begin
        rec_sum  = r_full + PW'(1024);
        t1       = rec_sum[63:11];
        t2       = r_full[53:0];
        rec_diff = 55'(r_t1) - 55'(t2);
        h_sat    = sat_h(PW'(rec_diff));
        ch_sum   = r_full + PW'(2048);
        ch_q     = ch_sum >>> 12;
        ch_sat   = sat_h(ch_q);
        kp_sat   = sat_h(r_full);
        case (r_d)
            2'd0:    acc_cur = r_acc0;
            2'd1:    acc_cur = r_acc1;
            2'd2:    acc_cur = r_acc2;
            default: acc_cur = r_acc3;
        endcase
        add_term = (r_op == OP_CH) ? ch_sat.val : kp_sat.val;
        acc_sum  = (HW+1)'(acc_cur) + (HW+1)'(add_term);
        acc_sat  = sat_h(PW'(acc_sum));
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_d     = r_d;
        n_n     = r_n;
        n_terms = r_terms;
        n_x     = r_x;
        n_hn    = r_hn;
        n_w1    = r_w1;
        n_w2    = r_w2;
        n_w3    = r_w3;
        n_k1    = r_k1;
        n_k2    = r_k2;
        n_k3    = r_k3;
        n_t1    = r_t1;
        n_p     = r_p;
        n_hi    = r_hi;
        n_full  = r_full;
        n_acc0  = r_acc0;
        n_acc1  = r_acc1;
        n_acc2  = r_acc2;
        n_acc3  = r_acc3;
        n_flag  = r_flag;
        o_re    = 1'b0;
        o_raddr = r_n[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_x = i_cmd.x_point;
                    if (32'(i_cmd.term_count) > MAX_TERMS) begin
                        n_terms = NW'(MAX_TERMS);
                    end else begin
                        n_terms = NW'(i_cmd.term_count);
                    end
                    n_n    = '0;
                    n_k1   = '0;
                    n_k2   = '0;
                    n_k3   = '0;
                    n_acc0 = '0;
                    n_acc1 = '0;
                    n_acc2 = '0;
                    n_acc3 = '0;
                    n_flag = 1'b0;
                    n_state = (i_cmd.term_count == '0) ? S_DONE : S_TERM;
                end
            end
            S_TERM: begin
                o_re = 1'b1;
                if (r_n == '0) begin
                    n_hn = ONE_Q12;
                end else if (r_n == NW'(1)) begin
                    n_hn = HW'(r_x) <<< 1;
                end
                n_d = 2'd0;
                n_op = (r_n >= NW'(2)) ? OP_REC1 : OP_CH;
                n_state = S_HI;
            end
            S_HI: begin
                n_state = S_LO;
            end
            S_LO: begin
                n_hi = mul_p;
                n_state = S_SUM;
            end
            S_SUM: begin
                n_full = (PW'(r_hi) <<< SL_W) + PW'(mul_p);
                n_state = S_POST;
            end
            S_POST: begin
                n_state = S_HI;
                unique case (r_op)
                    OP_REC1: begin
                        n_t1 = t1;
                        n_op = OP_REC2;
                    end
                    OP_REC2: begin
                        n_hn   = h_sat.val;
                        n_flag = r_flag | h_sat.clip;
                        n_op   = OP_CH;
                        n_d    = 2'd0;
                    end
                    OP_CH: begin
                        n_p    = ch_sat.val;
                        n_flag = r_flag | ch_sat.clip;
                        if (r_d == 2'd0) begin
                            n_acc0 = acc_sat.val;
                            n_flag = r_flag | ch_sat.clip | acc_sat.clip;
                            if (r_n != '0) begin
                                n_d = 2'd1;
                            end else begin
                                n_state = S_NEXT;
                            end
                        end else begin
                            n_op = OP_KP;
                        end
                    end
                    default: begin
                        n_flag = r_flag | kp_sat.clip | acc_sat.clip;
                        case (r_d)
                            2'd1:    n_acc1 = acc_sat.val;
                            2'd2:    n_acc2 = acc_sat.val;
                            default: n_acc3 = acc_sat.val;
                        endcase
                        if (r_d != 2'd3 && r_n > NW'(r_d)) begin
                            n_op = OP_CH;
                            n_d  = r_d + 2'd1;
                        end else begin
                            n_state = S_NEXT;
                        end
                    end
                endcase
            end
            S_NEXT: begin
                n_w3 = r_w2;
                n_w2 = r_w1;
                n_w1 = r_hn;
                // 4n(n-1) grows by 8n, 8n(n-1)(n-2) by six times 4n(n-1)
                n_k3 = r_k3 + (r_k2 << 2) + (r_k2 << 1);
                n_k2 = r_k2 + (r_k1 << 2);
                n_k1 = r_k1 + KW'(2);
                n_n  = r_n + NW'(1);
                n_state = (r_n + NW'(1) == r_terms) ? S_DONE : S_TERM;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_d     <= n_d;
        r_n     <= n_n;
        r_terms <= n_terms;
        r_x     <= n_x;
        r_hn    <= n_hn;
        r_w1    <= n_w1;
        r_w2    <= n_w2;
        r_w3    <= n_w3;
        r_k1    <= n_k1;
        r_k2    <= n_k2;
        r_k3    <= n_k3;
        r_t1    <= n_t1;
        r_p     <= n_p;
        r_hi    <= n_hi;
        r_full  <= n_full;
        r_acc0  <= n_acc0;
        r_acc1  <= n_acc1;
        r_acc2  <= n_acc2;
        r_acc3  <= n_acc3;
        r_flag  <= n_flag;
    end

    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.res_valid = (r_state == S_DONE);

    assign o_res.value        = r_acc0;
    assign o_res.first_deriv  = r_acc1;
    assign o_res.second_deriv = r_acc2;
    assign o_res.third_deriv  = r_acc3;
    assign o_res.saturated    = r_flag;

endmodule
`default_nettype wire

/* design/hermite_series_eval_derivs_top.sv */
// schedule: an evaluate forms each 32x48 product on the one 32x25 multiplier, stepping through
//   S_HI, S_LO, S_SUM and S_POST, upper slice first and then the lower slice
// throughput: one evaluate at a time, o_in_ready low while it runs; a load leaves o_in_ready high
// and loads may follow back to back
// reset: synchronous active-low i_rst_n clears control, term_count returns to 10;
//   the coefficient table is not cleared and must be loaded before use
`default_nettype none
module hermite_series_eval_derivs_top
    import hsed_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // item input
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in_item,
    // result output
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_item,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    localparam int AW = $clog2(MAX_TERMS);

    logic [4:0]  r_term_count;
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic        in_xact;
    logic        cfg_wr;
    logic        reg_idx;
    logic        ram_we;
    logic        ram_re;
    logic [AW-1:0] ram_raddr;
    logic [CW-1:0] ram_rdata;
    t_seq_cmd    seq_cmd;
    t_seq_stat   seq_stat;
    t_out_item   seq_res;
    logic        res_take;

    // --- configuration register ---
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= TERM_COUNT_RST;
        end else if (cfg_wr && reg_idx == REG_TERM_COUNT) begin
            r_term_count <= pwdata[4:0];
        end
    end

    // register map holds one entry; everything else reads zero
    assign prdata = (reg_idx == REG_TERM_COUNT) ? APB_DW'(r_term_count) : '0;

    // --- input side ---
    // items are only taken while the sequencer is idle
    assign o_in_ready = seq_stat.idle;
    assign in_xact    = i_in_valid && o_in_ready;

    // load: write one table entry, drop indexes past the table
    assign ram_we = in_xact && (i_in_item.action == ACT_LOAD)
                    && (32'(i_in_item.coef_index) < MAX_TERMS);

    hsed_coef_ram #(
        .DEPTH (MAX_TERMS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_in_item.coef_index)),
        .i_wdata (i_in_item.coef_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // evaluate: hand x and the current term count to the sequencer
    assign seq_cmd.start      = in_xact && (i_in_item.action == ACT_EVAL);
    assign seq_cmd.x_point    = i_in_item.x_point;
    assign seq_cmd.term_count = r_term_count;

    hsed_seq #(
        .MAX_TERMS (MAX_TERMS),
        .AW        (AW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (seq_cmd),
        .o_stat     (seq_stat),
        .o_res      (seq_res),
        .i_res_take (res_take),
        .o_re       (ram_re),
        .o_raddr    (ram_raddr),
        .i_rdata    (ram_rdata)
    );

    // --- output register ---
    // the finished result moves here as soon as the slot is free, so the sequencer
    // can return to idle while the downstream side still stalls
    assign res_take = seq_stat.res_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_item <= seq_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

/* design/hsed_checker.sv */
`default_nettype none
module hsed_checker
    import hsed_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_ready,
    input wire t_in_item          i_in_item,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire t_out_item         o_out_item
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed or dropped while stalled");

    // an evaluate transaction occupies the block
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.action == ACT_EVAL |=> !o_in_ready)
        else $error("ready stayed high after an evaluate");

    // a load leaves the block ready for the next item
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.action == ACT_LOAD |=> o_in_ready)
        else $error("ready dropped after a load");

    // a new result only follows an evaluation in progress
    a_res_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared with no evaluation running");

endmodule

bind hermite_series_eval_derivs_top hsed_checker u_hsed_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
`default_nettype wire

/* tb/hermite_series_eval_derivs_top_tb.sv */
`default_nettype none
module hermite_series_eval_derivs_top_tb
    import hsed_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // coefficient slots in the table, same as the block default
    localparam int TERM_SLOTS = MAX_TERMS_DEF;

    // register map: term_count is register 0, the next word is unmapped
    localparam logic [APB_AW-1:0] ADDR_TERM_COUNT = APB_AW'(4 * REG_TERM_COUNT);
    localparam logic [APB_AW-1:0] ADDR_SPARE      = ADDR_TERM_COUNT + APB_AW'(4);

    // 48-bit saturation bounds and the product split limit, as 64-bit integers
    localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SAT_LO = -SAT_HI - 1;
    localparam longint SPLIT  = 64'sd1 <<< 50;

    // the limit covers a thousand sixteen-term evaluates plus the worst sender gaps
    // and receiver stalls several times over
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 600;
    localparam int PRINT_CAP     = 30;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 120;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_item;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out_item;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // shadow of the block: coefficient table and term count
    logic signed [CW-1:0] coef_tab [TERM_SLOTS];
    logic [4:0]           cfg_terms;

    // evaluations accepted by the block whose results have not come back yet
    t_out_item            pending_evals [$];

    int                   mismatch_count;
    int                   loads_sent;
    int                   evals_checked;
    int                   clipped_results;
    int                   cycle_count;
    bit                   tx_steady;    // sender never idles while set
    bit                   rx_steady;    // receiver never stalls while set

    hermite_series_eval_derivs_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // series predictor
    // ------------------------------------------------------------------

    // clip to the signed 48-bit range, noting any clip
    function automatic longint clip48(input longint v, inout bit hit);
        if (v > SAT_HI) begin
            hit = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO) begin
            hit = 1'b1;
            return SAT_LO;
        end
        return v;
    endfunction

    // Q15.16 coefficient times Q35.12 polynomial value, rounded to Q.16;
    // the polynomial is split into a high part and a low 24-bit slice
    function automatic longint coef_times_h(input longint c, input longint h, inout bit hit);
        longint hi_part;
        longint lo_part;
        longint a;
        longint b;
        hi_part = h >>> 24;
        lo_part = h & 64'h0000_0000_00FF_FFFF;
        a = c * hi_part;
        b = c * lo_part;
        if (a > SPLIT) begin
            hit = 1'b1;
            return SAT_HI;
        end
        if (a < -SPLIT) begin
            hit = 1'b1;
            return SAT_LO;
        end
        return clip48(a * 4096 + ((b + 2048) >>> 12), hit);
    endfunction

    // exact integer derivative factor with saturation
    function automatic longint scale_by(input longint p, input longint k, inout bit hit);
        if (k == 0) begin
            return 0;
        end
        if (p > SAT_HI / k) begin
            hit = 1'b1;
            return SAT_HI;
        end
        if (p < SAT_LO / k) begin
            hit = 1'b1;
            return SAT_LO;
        end
        return p * k;
    endfunction

    // series value and three derivatives at x, from the shadow table
    function automatic t_out_item eval_series(input logic signed [XW-1:0] x_in);
        longint    herm [TERM_SLOTS];
        longint    sums [4];
        longint    x;
        longint    k;
        longint    t1;
        longint    t2;
        longint    term;
        bit        hit;
        int        terms;
        t_out_item r;
        x     = longint'(x_in);
        hit   = 1'b0;
        terms = (cfg_terms > TERM_SLOTS) ? TERM_SLOTS : int'(cfg_terms);
        for (int d = 0; d < 4; d++) begin
            sums[d] = 0;
        end
        for (int n = 0; n < terms; n++) begin
            if (n == 0) begin
                herm[n] = 4096;
            end else if (n == 1) begin
                herm[n] = 2 * x;
            end else begin
                t1 = (x * herm[n-1] + 1024) >>> 11;
                t2 = 2 * longint'(n - 1) * herm[n-2];
                herm[n] = clip48(t1 - t2, hit);
            end
        end
        for (int n = 0; n < terms; n++) begin
            for (int d = 0; d < 4; d++) begin
                if (n >= d) begin
                    case (d)
                        0: k = 1;
                        1: k = 2 * longint'(n);
                        2: k = 4 * longint'(n) * (n - 1);
                        default: k = 8 * longint'(n) * (n - 1) * (n - 2);
                    endcase
                    term = coef_times_h(longint'(coef_tab[n]), herm[n-d], hit);
                    term = scale_by(term, k, hit);
                    sums[d] = clip48(sums[d] + term, hit);
                end
            end
        end
        r.value        = sums[0][HW-1:0];
        r.first_deriv  = sums[1][HW-1:0];
        r.second_deriv = sums[2][HW-1:0];
        r.third_deriv  = sums[3][HW-1:0];
        r.saturated    = hit;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_in_item make_item(input logic act, input logic [3:0] idx,
                                           input logic signed [CW-1:0] coef,
                                           input logic signed [XW-1:0] x);
        t_in_item it;
        it.action     = act;
        it.coef_index = idx;
        it.coef_value = coef;
        it.x_point    = x;
        return it;
    endfunction

    // mostly modest coefficients so that results stay in range, plus full-scale ones
    function automatic logic signed [CW-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return CW'($urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
            5, 6, 7:       return CW'($urandom);
            8:             return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default:       return CW'($urandom_range(0, 32'h0200_0000) - 32'h0100_0000);
        endcase
    endfunction

    // mostly |x| up to 1.5, where few terms clip, plus the whole Q3.12 range
    function automatic logic signed [XW-1:0] pick_x();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return XW'($urandom_range(0, 12288) - 6144);
            6, 7:             return XW'($urandom);
            8:                return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default:          return $urandom_range(0, 1) ? 16'sh1000 : -16'sh1000;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < PRINT_CAP) begin
            $display("error: %s, got %0d, expected %0d", what, got, want);
        end
        mismatch_count++;
    endtask

    // one input transaction; called at a falling edge, returns at a falling edge
    // with valid still high so that a zero gap keeps it high across items
    task automatic send_item(input t_in_item item);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_item  <= item;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        // accepted at this edge: update the shadow or queue the expected result
        if (item.action == ACT_LOAD) begin
            coef_tab[item.coef_index] = item.coef_value;
            loads_sent++;
        end else begin
            pending_evals.push_back(eval_series(item.x_point));
        end
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // block goes idle: nothing outstanding, then a SETTLE_CYCLES wait for a trailing load
    task automatic wait_drained();
        stop_sending();
        while (pending_evals.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_TERM_COUNT) begin
            cfg_terms = data[4:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // read term_count back and compare with the shadow
    task automatic check_term_count();
        logic [APB_DW-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_TERM_COUNT;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        if (rd[4:0] !== cfg_terms) begin
            note_mismatch("term_count read back", longint'(rd[4:0]), longint'(cfg_terms));
        end
    endtask

    // upper data bits are junk; only the low five belong to the register
    task automatic set_term_count(input logic [4:0] count);
        wait_drained();
        apb_write(ADDR_TERM_COUNT, {(APB_DW-5)'($urandom), count});
        check_term_count();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every table entry is written before any evaluation, so no evaluation at any
    // term count ever reads an entry that was never loaded
    task automatic test_table_load();
        logic signed [CW-1:0] coef;
        check_term_count();
        for (int i = 0; i < TERM_SLOTS; i++) begin
            case (i)
                0:       coef = 32'sh0001_0000;     // 1.0
                1:       coef = -32'sh0001_0000;
                2:       coef = 32'sh7FFF_FFFF;
                3:       coef = 32'sh8000_0000;
                4:       coef = 32'sh0000_0000;
                5:       coef = 32'sh0000_0001;
                6:       coef = -32'sh0000_0001;
                default: coef = pick_coef();
            endcase
            // x_point is don't-care on a load, push it to both extremes
            send_item(make_item(ACT_LOAD, 4'(i), coef, (i % 2) ? 16'sh7FFF : 16'sh8000));
        end
    endtask

    // x at zero, plus and minus one, the extremes and one lsb; the coefficient
    // fields of an evaluate are don't-care and carry extreme junk
    task automatic test_point_extremes();
        logic signed [XW-1:0] xs [6];
        xs = '{16'sh0000, 16'sh1000, -16'sh1000, 16'sh7FFF, 16'sh8000, 16'sh0001};
        for (int i = 0; i < 6; i++) begin
            send_item(make_item(ACT_EVAL, (i % 2) ? 4'hF : 4'h0,
                                (i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000, xs[i]));
        end
    endtask

    // zero terms gives all zeros, counts above the table size clamp, and the
    // unmapped word must not touch term_count
    task automatic test_term_count_sweep();
        logic [4:0] counts [7];
        counts = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd16, 5'd17, 5'd31};
        for (int i = 0; i < 7; i++) begin
            set_term_count(counts[i]);
            send_item(make_item(ACT_EVAL, 4'($urandom), CW'($urandom), 16'sh1800));
        end
        wait_drained();
        apb_write(ADDR_SPARE, 32'h0000_0003);
        check_term_count();
        send_item(make_item(ACT_EVAL, 4'($urandom), CW'($urandom), -16'sh1800));
        set_term_count(TERM_COUNT_RST);
    endtask

    // phases of mixed loads and evaluates, each at its own term count
    task automatic test_random_traffic();
        logic [4:0] count;
        t_in_item   item;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       count = 5'd16;
                1:       count = 5'd1;
                default: count = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 31))
                                                             : 5'($urandom_range(1, 16));
            endcase
            set_term_count(count);
            // one phase with no idling at all, one with a steady receiver only
            tx_steady = (phase == 2);
            rx_steady = (phase == 2) || (phase == 5);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // halfway through one phase the sender holds off until all is back
                if (phase == 3 && i == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                if ($urandom_range(0, 9) < 3) begin
                    item = make_item(ACT_LOAD, 4'($urandom), pick_coef(), XW'($urandom));
                end else begin
                    item = make_item(ACT_EVAL, 4'($urandom), CW'($urandom), pick_x());
                end
                send_item(item);
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // receiver: before each result draws a random stall; a nonzero
    // stall holds ready low until the result shows up and then a while longer
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 7);
            i_out_ready <= (stall == 0);
            if (stall != 0) begin
                do @(posedge i_clk); while (!o_out_valid);
                repeat (stall) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // result checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_evals.size() == 0) begin
                note_mismatch("result with no evaluation pending", 0, 0);
            end else begin
                want = pending_evals.pop_front();
                if (o_out_item.value !== want.value) begin
                    note_mismatch("value", longint'(o_out_item.value), longint'(want.value));
                end
                if (o_out_item.first_deriv !== want.first_deriv) begin
                    note_mismatch("first_deriv", longint'(o_out_item.first_deriv),
                                  longint'(want.first_deriv));
                end
                if (o_out_item.second_deriv !== want.second_deriv) begin
                    note_mismatch("second_deriv", longint'(o_out_item.second_deriv),
                                  longint'(want.second_deriv));
                end
                if (o_out_item.third_deriv !== want.third_deriv) begin
                    note_mismatch("third_deriv", longint'(o_out_item.third_deriv),
                                  longint'(want.third_deriv));
                end
                if (o_out_item.saturated !== want.saturated) begin
                    note_mismatch("saturated", longint'(o_out_item.saturated),
                                  longint'(want.saturated));
                end
                evals_checked++;
                if (want.saturated) begin
                    clipped_results++;
                end
            end
        end
    end

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_evals.size());
            $display("hermite_series_eval_derivs_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        // every input known from time zero, reset held low before the tests start
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_item       = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        cfg_terms       = TERM_COUNT_RST;
        mismatch_count  = 0;
        loads_sent      = 0;
        evals_checked   = 0;
        clipped_results = 0;
        cycle_count     = 0;
        tx_steady       = 1'b0;
        rx_steady       = 1'b0;
        for (int i = 0; i < TERM_SLOTS; i++) begin
            coef_tab[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_table_load();
        test_point_extremes();
        test_term_count_sweep();
        test_random_traffic();

        // everything back, then watch a while for stray results
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (pending_evals.size() != 0) begin
            note_mismatch("evaluations never answered", pending_evals.size(), 0);
        end

        $display("covered %0d coefficient loads and %0d evaluations, %0d of them clipped,",
                 loads_sent, evals_checked, clipped_results);
        $display("term counts from 0 to 31, with and without sender gaps and receiver stalls");
        if (mismatch_count == 0) begin
            $display("hermite_series_eval_derivs_top: match");
        end else begin
            $display("hermite_series_eval_derivs_top: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
design/hsed_pkg.sv
design/hsed_coef_ram.sv
design/hsed_mul.sv
design/hsed_seq.sv
design/hermite_series_eval_derivs_top.sv
design/hsed_checker.sv
tb/hermite_series_eval_derivs_top_tb.sv
